// ----- hw/rtl/sli_pkg.sv -----
// sli_pkg: shared types and constants of the sorted list block
// used by the channel interfaces, the cell chain and the top level
package sli_pkg;

  // default depth of the list
  localparam int unsigned CAPACITY_DEF = 16;

  // fixed field widths of the request and result words
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned ENTRY_CNT_W = 5;

  typedef logic signed [VALUE_W-1:0] sli_val_t;

  // request codes; the fourth code is unused
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } sli_req_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } sli_status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } sli_op_e;

  typedef struct packed {
    sli_op_e  op;
    sli_val_t value;
  } sli_ctrl_t;

endpackage

// ----- hw/rtl/sli_if.sv -----
// sli_if: valid/ready channel interfaces for request and result words
// depends on sli_pkg for the value type and the field widths
interface sli_req_if;
  import sli_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  sli_val_t               value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sli_rsp_if;
  import sli_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  sli_val_t               entry_value;
  logic                   is_last;
  logic [ENTRY_CNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_value, output is_last,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input entry_value, input is_last,
                  input entry_count, output ready);
endinterface

// ----- hw/rtl/sli_cell.sv -----
// sli_cell: one slot of the sorted list, holds a value and a valid bit
// compares against the broadcast value and trades data with its neighbors; uses sli_pkg
module sli_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sli_pkg::sli_ctrl_t ctrl_i,
  input  sli_pkg::sli_val_t prev_value_i,
  input  logic              prev_valid_i,
  input  logic              prev_lt_i,
  input  sli_pkg::sli_val_t next_value_i,
  input  logic              next_valid_i,
  input  sli_pkg::sli_val_t head_value_i,
  output sli_pkg::sli_val_t value_o,
  output logic              valid_o,
  output logic              lt_o,
  output logic              eq_o
);
  import sli_pkg::*;

  sli_val_t value_q, value_d;
  logic     valid_q, valid_d;

  // compare stored entry with the broadcast value
  assign lt_o = valid_q && (value_q < ctrl_i.value);
  assign eq_o = valid_q && (value_q == ctrl_i.value);

  // next contents per operation
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INS: begin
        // cells at or past the insert point take the new value or shift right
        if (!lt_o) begin
          value_d = prev_lt_i ? ctrl_i.value : prev_value_i;
          valid_d = valid_q | prev_valid_i;
        end
      end
      OP_DEL: begin
        // cells at or past the first match shift left
        if (!lt_o) begin
          value_d = next_value_i;
          valid_d = next_valid_i;
        end
      end
      OP_ROT: begin
        // rotate valid entries left, the head value wraps to the last valid cell
        if (valid_q) begin
          value_d = next_valid_i ? next_value_i : head_value_i;
        end
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ----- hw/rtl/sli_chain.sv -----
// sli_chain: row of sli_cell slots wired to their neighbors
// depends on sli_pkg and sli_cell
module sli_chain #(
  parameter int unsigned CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sli_pkg::sli_ctrl_t ctrl_i,
  output sli_pkg::sli_val_t  head_value_o,
  output logic               eq_any_o,
  output logic [CAPACITY-1:0] valid_o
);
  import sli_pkg::*;

  sli_val_t            cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  // build the row; the head sees an always-smaller left neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sli_val_t prev_value, next_value;
    logic     prev_valid, prev_lt, next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b1;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .head_value_i (cell_value[0]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  assign head_value_o = cell_value[0];
  assign eq_any_o     = |cell_eq;
  assign valid_o      = cell_valid;

endmodule

// ----- hw/rtl/sorted_list_insert_delete.sv -----
// sorted_list_insert_delete: ascending list of signed values held in a row of cells
// insert and delete: accept, then an update step with the result registered, held while the output slot is full
// a dump of N entries: accept, a decode step, then one word per cycle while the output
// slot is free, as the row rotates past the head
// one request at a time; each step is a single broadcast compare-and-shift across all cells
// reset clears the count and every cell valid bit; entry contents are not cleared
// depends on sli_pkg, sli_if and sli_chain
module sorted_list_insert_delete #(
  parameter int unsigned CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_req_if.sink   req_i,
  sli_rsp_if.source rsp_o
);
  import sli_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  state_e                 state_q;
  logic [REQ_W-1:0]       req_q;
  sli_val_t               val_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    out_status_q;
  sli_val_t               out_value_q;
  logic                   out_last_q;
  logic [ENTRY_CNT_W-1:0] out_count_q;

  sli_ctrl_t              ctrl;
  sli_op_e                exec_op;
  sli_status_e            exec_status;
  sli_val_t               head_value;
  logic                   eq_any;
  logic [CAPACITY-1:0]    cell_valid;
  logic                   slot_free;
  logic                   req_fire;
  logic                   dump_last;
  logic                   out_load;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_fire  = req_i.valid && req_i.ready;
  assign dump_last = (idx_q + CNT_W'(1)) == count_q;

  // a new result word enters the output register
  assign out_load = slot_free &&
                    ((state_q == S_EXEC && !(req_q == REQ_DUMP && count_q != '0)) ||
                     state_q == S_DUMP);

  // decode the held request against the current list
  always_comb begin
    exec_op     = OP_HOLD;
    exec_status = ST_OK;
    count_d     = count_q;
    case (req_q)
      REQ_INSERT: begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          exec_status = ST_FULL;
        end else begin
          exec_op = OP_INS;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (count_q == '0) begin
          exec_status = ST_EMPTY;
        end else if (!eq_any) begin
          exec_status = ST_NOT_FOUND;
        end else begin
          exec_op = OP_DEL;
          count_d = count_q - CNT_W'(1);
        end
      end
      REQ_DUMP: begin
        if (count_q == '0) begin
          exec_status = ST_EMPTY;
        end
      end
      default: begin
        exec_status = ST_OK;
      end
    endcase
  end

  // operation broadcast to the row
  always_comb begin
    ctrl.value = val_q;
    ctrl.op    = OP_HOLD;
    if (state_q == S_EXEC && slot_free) begin
      ctrl.op = exec_op;
    end else if (state_q == S_DUMP && slot_free) begin
      ctrl.op = OP_ROT;
    end
  end

  sli_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .head_value_o (head_value),
    .eq_any_o     (eq_any),
    .valid_o      (cell_valid)
  );

  // sequencer and result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      val_q        <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_count_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            req_q   <= req_i.req_type;
            val_q   <= req_i.value;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_q == REQ_DUMP && count_q != '0) begin
            idx_q   <= '0;
            state_q <= S_DUMP;
          end else if (slot_free) begin
            count_q      <= count_d;
            out_status_q <= exec_status;
            out_value_q  <= '0;
            out_last_q   <= 1'b1;
            out_count_q  <= ENTRY_CNT_W'(count_d);
            state_q      <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            out_status_q <= ST_OK;
            out_value_q  <= head_value;
            out_last_q   <= dump_last;
            out_count_q  <= ENTRY_CNT_W'(count_q);
            idx_q        <= idx_q + CNT_W'(1);
            if (dump_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_value = out_value_q;
  assign rsp_o.is_last     = out_last_q;
  assign rsp_o.entry_count = out_count_q;

  // expected valid mask from the count
  logic [CAPACITY-1:0] valid_mask;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_mask
    assign valid_mask[i] = (CNT_W'(i) < count_q);
  end

  // cell valid bits always form a prefix as long as the count
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid == valid_mask)
    else $error("cell valid bits disagree with entry count");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count jumped");

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a dump only walks a non-empty list and stays within it
  a_dump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (count_q != '0 && idx_q < count_q))
    else $error("dump index out of range");

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for sorted_list_insert_delete over valid/ready channels
// depends on sli_pkg, the sli_req_if/sli_rsp_if interfaces and the top level rtl
module tb;
  import sli_pkg::*;

  localparam int unsigned LIST_DEPTH  = CAPACITY_DEF;
  localparam int unsigned RANDOM_REQS = 500;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned DRAIN_WAIT  = 40;

  // request code with no operation behind it
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    sli_val_t               entry_value;
    logic                   is_last;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } list_word_t;

  // shadow copy of the list and the words it should produce
  class list_scoreboard;
    sli_val_t   stored[$];
    list_word_t expected_words[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function void push_word(logic [STATUS_W-1:0] st, sli_val_t v, logic last);
      list_word_t w;
      w.status      = st;
      w.entry_value = v;
      w.is_last     = last;
      w.entry_count = ENTRY_CNT_W'(stored.size());
      expected_words.push_back(w);
    endfunction

    // update the shadow list for one accepted request
    function void note_request(logic [REQ_W-1:0] kind, sli_val_t v);
      int pos;
      pos = 0;
      case (kind)
        REQ_INSERT: begin
          if (stored.size() >= LIST_DEPTH) begin
            push_word(ST_FULL, '0, 1'b1);
          end else begin
            // ahead of the first entry that is not smaller
            while (pos < stored.size() && stored[pos] < v) pos++;
            stored.insert(pos, v);
            push_word(ST_OK, '0, 1'b1);
          end
        end
        REQ_DELETE: begin
          if (stored.size() == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else begin
            while (pos < stored.size() && stored[pos] != v) pos++;
            if (pos >= stored.size()) begin
              push_word(ST_NOT_FOUND, '0, 1'b1);
            end else begin
              stored.delete(pos);
              push_word(ST_OK, '0, 1'b1);
            end
          end
        end
        REQ_DUMP: begin
          if (stored.size() == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < stored.size(); i++)
              push_word(ST_OK, stored[i], (i == stored.size() - 1));
          end
        end
        default: begin
          push_word(ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    // compare one result word against the oldest expectation
    function void check_word(logic [STATUS_W-1:0] st, sli_val_t v, logic last,
                             logic [ENTRY_CNT_W-1:0] cnt);
      list_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing pending: status %0d entry_value %0d", st, v);
        failures++;
        return;
      end
      w = expected_words.pop_front();
      if (st !== w.status) begin
        $error("status mismatch: expected %0d, got %0d", w.status, st);
        failures++;
      end
      if (v !== w.entry_value) begin
        $error("entry_value mismatch: expected %0d, got %0d", w.entry_value, v);
        failures++;
      end
      if (last !== w.is_last) begin
        $error("is_last mismatch: expected %0d, got %0d", w.is_last, last);
        failures++;
      end
      if (cnt !== w.entry_count) begin
        $error("entry_count mismatch: expected %0d, got %0d", w.entry_count, cnt);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sli_req_if req_ch ();
  sli_rsp_if rsp_ch ();

  list_scoreboard sb = new();
  int unsigned    sent_count  = 0;
  int unsigned    words_seen  = 0;
  int unsigned    idle_cycles = 0;

  sorted_list_insert_delete #(
    .CAPACITY (LIST_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  // 20 unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // value mix: small range for duplicates, extremes, full random
  function automatic sli_val_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return sli_val_t'(int'($urandom_range(0, 8)) - 4);
    if (sel == 3) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return sli_val_t'($urandom());
  endfunction

  // delete targets mostly hit a stored entry
  function automatic sli_val_t pick_victim();
    if (sb.stored.size() != 0 && $urandom_range(0, 3) != 0)
      return sb.stored[$urandom_range(0, sb.stored.size() - 1)];
    return pick_value();
  endfunction

  // offer one request word and wait for it to be taken
  task automatic send_request(input logic [REQ_W-1:0] kind, input sli_val_t v);
    int unsigned gap;
    gap = ((sent_count % 50) < 10) ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(kind, v);
    sent_count++;
  endtask

  // result side: random stalls, two long hold-offs to back up the list
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (words_seen == 40 || words_seen == 400)
        stall = HOLD_CYCLES;
      else if ((words_seen % 64) < 16)
        stall = 0;
      else
        stall = $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      sb.check_word(rsp_ch.status, rsp_ch.entry_value, rsp_ch.is_last, rsp_ch.entry_count);
      words_seen++;
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    forever begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // reset, directed requests, random requests, drain
  initial begin
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned del_pct;
    bit          filling;
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.value    = '0;
    filling         = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list corner cases
    send_request(REQ_DUMP, 32'sd0);
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_UNUSED, 32'sd0);
    // fill to capacity with extremes and duplicates
    send_request(REQ_INSERT, 32'sh7fffffff);
    send_request(REQ_INSERT, 32'sh80000000);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, 32'sd1);
    for (int i = 0; i < 10; i++)
      send_request(REQ_INSERT, sli_val_t'(i * 3 - 10));
    // full list, dump all, absent value, extremes out
    send_request(REQ_INSERT, 32'sd7);
    send_request(REQ_DUMP, 32'sd0);
    send_request(REQ_DELETE, 32'sd1000);
    send_request(REQ_DELETE, 32'sh7fffffff);
    send_request(REQ_DELETE, 32'sh80000000);
    send_request(REQ_DUMP, 32'sd0);

    // random mix, alternating fill and drain phases
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) filling = !filling;
      ins_pct = filling ? 60 : 25;
      del_pct = filling ? 25 : 60;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        send_request(REQ_INSERT, pick_value());
      else if (roll < ins_pct + del_pct)
        send_request(REQ_DELETE, pick_victim());
      else if (roll < 97)
        send_request(REQ_DUMP, pick_value());
      else
        send_request(REQ_UNUSED, pick_value());
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sli_pkg.sv
hw/rtl/sli_if.sv
hw/rtl/sli_cell.sv
hw/rtl/sli_chain.sv
hw/rtl/sorted_list_insert_delete.sv
bench/tb.sv
